// ===== src/mbl_pkg.sv =====
// Shared types and constants for the morphological baseline block.
package mbl_pkg;

  localparam int HW_BITS    = 5;
  localparam int APB_DW     = 32;
  localparam int PADDR_BITS = 3;

  localparam logic [HW_BITS-1:0] HALF_WINDOW_RESET = 5'd10;
  localparam logic               REG_HALF_WINDOW   = 1'b0;

  typedef struct packed {
    logic live;
    logic first;
    logic last;
  } tag_t;

endpackage

// ===== src/mbl_cell.sv =====
// One window cell: running min and max over its lag span, plus a tag and raw sample tap.
module mbl_cell #(
  parameter int SB = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 clear,
  input  logic                 restart,
  input  logic signed [SB-1:0] lo_push,
  input  logic signed [SB-1:0] hi_push,
  input  logic signed [SB-1:0] lo_prev,
  input  logic signed [SB-1:0] hi_prev,
  input  logic signed [SB-1:0] raw_prev,
  input  mbl_pkg::tag_t        tag_prev,
  output logic signed [SB-1:0] lo_r,
  output logic signed [SB-1:0] hi_r,
  output logic signed [SB-1:0] raw_r,
  output mbl_pkg::tag_t        tag_r
);

  logic signed [SB-1:0] lo_nxt;
  logic signed [SB-1:0] hi_nxt;

  always_comb begin
    if (restart) begin
      lo_nxt = lo_push;
      hi_nxt = hi_push;
    end else begin
      lo_nxt = (lo_push < lo_prev) ? lo_push : lo_prev;
      hi_nxt = (hi_push > hi_prev) ? hi_push : hi_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      tag_r <= '0;
    end else if (adv) begin
      tag_r <= tag_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      raw_r <= raw_prev;
    end
  end

endmodule

// ===== src/mbl_stage.sv =====
// Chain of window cells giving a centred clipped min and max over 2w+1 positions.
module mbl_stage #(
  parameter int SB       = 16,
  parameter int MAX_HALF = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic                                 clear,
  input  logic [$clog2(MAX_HALF+1)-1:0]        w,
  input  mbl_pkg::tag_t                        in_tag,
  input  logic signed [SB-1:0]                 in_lo,
  input  logic signed [SB-1:0]                 in_hi,
  input  logic signed [SB-1:0]                 in_raw,
  output mbl_pkg::tag_t                        out_tag,
  output logic signed [SB-1:0]                 out_lo,
  output logic signed [SB-1:0]                 out_hi,
  output logic signed [SB-1:0]                 out_raw
);

  localparam int D  = 2*MAX_HALF + 1;
  localparam int IB = $clog2(D);
  localparam logic signed [SB-1:0] PAD_LO = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] PAD_HI = {1'b1, {(SB-1){1'b0}}};

  logic signed [SB-1:0] cell_lo  [D];
  logic signed [SB-1:0] cell_hi  [D];
  logic signed [SB-1:0] cell_raw [D];
  mbl_pkg::tag_t        cell_tag [D];

  logic signed [SB-1:0] lo_push;
  logic signed [SB-1:0] hi_push;
  logic                 restart;
  logic [IB-1:0]        centre_idx;
  logic [IB-1:0]        edge_idx;

  assign lo_push    = in_tag.live ? in_lo : PAD_LO;
  assign hi_push    = in_tag.live ? in_hi : PAD_HI;
  assign restart    = in_tag.live && in_tag.first;
  assign centre_idx = IB'(w);
  assign edge_idx   = IB'({w, 1'b0});

  genvar i;
  generate
    for (i = 0; i < D; i++) begin : g_cell
      if (i == 0) begin : g_head
        mbl_cell #(.SB(SB)) u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .adv      (adv),
          .clear    (clear),
          .restart  (restart),
          .lo_push  (lo_push),
          .hi_push  (hi_push),
          .lo_prev  (lo_push),
          .hi_prev  (hi_push),
          .raw_prev (in_raw),
          .tag_prev (in_tag),
          .lo_r     (cell_lo[i]),
          .hi_r     (cell_hi[i]),
          .raw_r    (cell_raw[i]),
          .tag_r    (cell_tag[i])
        );
      end else begin : g_body
        mbl_cell #(.SB(SB)) u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .adv      (adv),
          .clear    (clear),
          .restart  (restart),
          .lo_push  (lo_push),
          .hi_push  (hi_push),
          .lo_prev  (cell_lo[i-1]),
          .hi_prev  (cell_hi[i-1]),
          .raw_prev (cell_raw[i-1]),
          .tag_prev (cell_tag[i-1]),
          .lo_r     (cell_lo[i]),
          .hi_r     (cell_hi[i]),
          .raw_r    (cell_raw[i]),
          .tag_r    (cell_tag[i])
        );
      end
    end
  endgenerate

  assign out_tag = cell_tag[centre_idx];
  assign out_raw = cell_raw[centre_idx];
  assign out_lo  = cell_lo[edge_idx];
  assign out_hi  = cell_hi[edge_idx];

endmodule

// ===== src/morphological_baseline.sv =====
// Top level of the morphological baseline estimator.
// Accepts one sample per cycle while out_ready is high and no flush runs, and delivers one
// baseline per sample, in order. Three cell chains (erosion, dilation, then min and max of
// the opening) each add w+1 positions of delay. After the sample marked last the block
// holds off input and keeps advancing the chains while the output is free, counting down
// a flush counter to drain the spectrum; a new spectrum starts on the next accepted sample.
module morphological_baseline #(
  parameter int MAX_HALF    = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [SAMPLE_BITS-1:0]         in_sample,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [SAMPLE_BITS-1:0]         out_baseline,
  output logic                                  out_end_of_run,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mbl_pkg::PADDR_BITS-1:0]        paddr,
  input  logic [mbl_pkg::APB_DW-1:0]            pwdata,
  output logic [mbl_pkg::APB_DW-1:0]            prdata,
  output logic                                  pready
);

  localparam int SB = SAMPLE_BITS;
  localparam int WB = $clog2(MAX_HALF+1);
  localparam int FB = $clog2(3*MAX_HALF+4);

  logic [mbl_pkg::HW_BITS-1:0] hw_r;
  logic [WB-1:0]               w_eff;
  logic                        reg_hit;
  logic                        cfg_wr;

  logic                        flushing_r;
  logic [FB-1:0]               flush_cnt_r;
  logic                        first_r;

  logic                        out_valid_r;
  logic signed [SB-1:0]        out_baseline_r;
  logic                        out_end_r;
  logic signed [SB-1:0]        baseline_nxt;

  logic                        out_free;
  logic                        in_acc;
  logic                        tick;

  mbl_pkg::tag_t               in_tag;
  mbl_pkg::tag_t               s1_tag;
  mbl_pkg::tag_t               s2_tag;
  mbl_pkg::tag_t               s3_tag;
  logic signed [SB-1:0]        s1_lo, s1_hi, s1_raw;
  logic signed [SB-1:0]        s2_lo, s2_hi, s2_raw;
  logic signed [SB-1:0]        s3_lo, s3_hi, s3_raw;
  logic signed [SB:0]          pair_sum;
  logic signed [SB-1:0]        mean;

  assign reg_hit = (paddr[mbl_pkg::PADDR_BITS-1] == mbl_pkg::REG_HALF_WINDOW);
  assign cfg_wr  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? mbl_pkg::APB_DW'(hw_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r <= mbl_pkg::HALF_WINDOW_RESET;
    end else if (cfg_wr) begin
      hw_r <= pwdata[mbl_pkg::HW_BITS-1:0];
    end
  end

  always_comb begin
    if (int'(hw_r) > MAX_HALF) begin
      w_eff = WB'(MAX_HALF);
    end else begin
      w_eff = WB'(hw_r);
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !flushing_r && out_free;
  assign in_acc   = in_valid && in_ready;
  assign tick     = in_acc || (flushing_r && out_free);

  assign in_tag.live  = in_acc;
  assign in_tag.first = first_r;
  assign in_tag.last  = in_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= 1'b1;
      flushing_r  <= 1'b0;
      flush_cnt_r <= '0;
    end else begin
      if (cfg_wr) begin
        first_r <= 1'b1;
      end else if (in_acc) begin
        first_r <= in_last;
      end
      if (in_acc && in_last) begin
        flushing_r  <= 1'b1;
        flush_cnt_r <= FB'(3*int'(w_eff) + 3);
      end else if (flushing_r && out_free) begin
        flush_cnt_r <= flush_cnt_r - FB'(1);
        if (flush_cnt_r == FB'(1)) begin
          flushing_r <= 1'b0;
        end
      end
    end
  end

  mbl_stage #(.SB(SB), .MAX_HALF(MAX_HALF)) u_erode (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (tick),
    .clear   (cfg_wr),
    .w       (w_eff),
    .in_tag  (in_tag),
    .in_lo   (in_sample),
    .in_hi   (in_sample),
    .in_raw  (in_sample),
    .out_tag (s1_tag),
    .out_lo  (s1_lo),
    .out_hi  (s1_hi),
    .out_raw (s1_raw)
  );

  mbl_stage #(.SB(SB), .MAX_HALF(MAX_HALF)) u_dilate (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (tick),
    .clear   (cfg_wr),
    .w       (w_eff),
    .in_tag  (s1_tag),
    .in_lo   (s1_lo),
    .in_hi   (s1_lo),
    .in_raw  (s1_raw),
    .out_tag (s2_tag),
    .out_lo  (s2_lo),
    .out_hi  (s2_hi),
    .out_raw (s2_raw)
  );

  mbl_stage #(.SB(SB), .MAX_HALF(MAX_HALF)) u_smooth (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (tick),
    .clear   (cfg_wr),
    .w       (w_eff),
    .in_tag  (s2_tag),
    .in_lo   (s2_hi),
    .in_hi   (s2_hi),
    .in_raw  (s2_raw),
    .out_tag (s3_tag),
    .out_lo  (s3_lo),
    .out_hi  (s3_hi),
    .out_raw (s3_raw)
  );

  assign pair_sum     = {s3_lo[SB-1], s3_lo} + {s3_hi[SB-1], s3_hi};
  assign mean         = pair_sum[SB:1];
  assign baseline_nxt = (s3_raw < mean) ? s3_raw : mean;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tick && s3_tag.live) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick && s3_tag.live) begin
      out_baseline_r <= baseline_nxt;
      out_end_r      <= s3_tag.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_baseline   = out_baseline_r;
  assign out_end_of_run = out_end_r;

  // input is held off once the drain starts after the final sample
  a_flush_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> (flushing_r && !in_ready))
    else $error("flush did not start after final sample");

  a_flush_count: assert property (@(posedge clk) disable iff (!rst_n)
    flushing_r |-> (flush_cnt_r != '0))
    else $error("flush count exhausted while draining");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !tick)
    else $error("pipeline advanced over a pending result");

endmodule
